[src/pcu_pkg.sv]
// Shared widths, register indexes and reset values for the clamped PID update block.
// No dependencies; used by pid_clamped_update_top.
package pcu_pkg;

  // field widths
  localparam int unsigned DataW    = 16;  // Q8.8 values, gains, limits; time step unsigned Q0.16
  localparam int unsigned ErrW     = 17;  // error, Q9.8
  localparam int unsigned DiffW    = 18;  // error difference, Q10.8
  localparam int unsigned AccW     = 32;  // integral, Q16.16
  localparam int unsigned QuotW    = 33;  // derivative magnitude
  localparam int unsigned OpW      = 34;  // serial multiplier operand (signed)
  localparam int unsigned HiW      = OpW + 1;
  localparam int unsigned ProdW    = HiW + DataW;
  localparam int unsigned SumW     = 60;  // drive sum at Q.24 scale
  localparam int unsigned CntW     = 4;   // one count per gain bit
  localparam int unsigned DivSteps = QuotW;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 32;  // measured, step_time

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegGainP     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTarget    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDriveLo   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDriveHi   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAccumLo   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegAccumHi   = 3'd7;

  // reset values
  localparam logic [DataW-1:0] GainPRst   = 16'h0100;      // 1.0
  localparam logic [DataW-1:0] GainIRst   = 16'h001A;      // ~0.1
  localparam logic [DataW-1:0] GainDRst   = 16'h000D;      // ~0.05
  localparam logic [DataW-1:0] TargetRst  = 16'h0000;
  localparam logic [DataW-1:0] DriveLoRst = 16'h9C00;      // -100.0
  localparam logic [DataW-1:0] DriveHiRst = 16'h6400;      // 100.0
  localparam logic [AccW-1:0]  AccumLoRst = 32'hFFCE_0000; // -50.0
  localparam logic [AccW-1:0]  AccumHiRst = 32'h0032_0000; // 50.0

  localparam logic [DataW-1:0] DriveMax = 16'h7FFF;
  localparam logic [DataW-1:0] DriveMin = 16'h8000;

endpackage

[src/pid_clamped_update_top.sv]
// Clamped fixed-point PID update: bit-serial multiplier and restoring divider.
// Depends on pcu_pkg for widths, register indexes and reset values.

// An update word holds the block from acceptance until its result is handed to
// the output register, and no new word is taken before then. The work is four
// passes of a shared shift-and-add multiplier (error times step time, then the
// proportional, integral and derivative gains, one multiplier bit per cycle),
// a fold after each pass, a saturation step and a step that hands the result
// to the output register; that last step stretches while the previous result
// is still unread. The 33-step restoring divider for the derivative runs beside
// the first passes and is done before the integral fold, which waits for the
// quotient. A zero step time skips the passes and gives a rejected result with
// a zero drive; a clear word gives no result. The result waits in an output
// register, so the next word is taken while the previous result is still unread.
module pid_clamped_update_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcu_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pcu_pkg::CfgDataW-1:0]    cfg_data_i,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pcu_pkg::InDataW-1:0]     s_axis_tdata,  // measured[15:0], step_time[31:16]
  input  logic [0:0]                      s_axis_tuser,  // action[0]
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pcu_pkg::DataW-1:0]       m_axis_tdata,  // drive[15:0]
  output logic [0:0]                      m_axis_tuser   // rejected[0]
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StFold,
    StSat,
    StResult
  } state_e;

  typedef enum logic [1:0] {
    PhDt,
    PhProp,
    PhInt,
    PhDer
  } phase_e;

  localparam int unsigned DW = pcu_pkg::DataW;
  localparam int unsigned EW = pcu_pkg::ErrW;
  localparam int unsigned FW = pcu_pkg::DiffW;
  localparam int unsigned AW = pcu_pkg::AccW;
  localparam int unsigned QW = pcu_pkg::QuotW;
  localparam int unsigned OW = pcu_pkg::OpW;
  localparam int unsigned HW = pcu_pkg::HiW;
  localparam int unsigned PW = pcu_pkg::ProdW;
  localparam int unsigned SW = pcu_pkg::SumW;
  localparam int unsigned CW = pcu_pkg::CntW;
  localparam int unsigned VW = pcu_pkg::DivCntW;

  // control and state registers
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [VW-1:0]   div_cnt_q, div_cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [DW-1:0]   gain_p_q, gain_p_d, gain_i_q, gain_i_d, gain_d_q, gain_d_d;
  logic [DW-1:0]   target_q, target_d, drive_lo_q, drive_lo_d, drive_hi_q, drive_hi_d;
  logic [AW-1:0]   accum_lo_q, accum_lo_d, accum_hi_q, accum_hi_d;
  logic [AW-1:0]   accum_q, accum_d;
  logic [EW-1:0]   last_err_q, last_err_d;

  // datapath registers
  logic [EW-1:0]   err_q, err_d;
  logic [DW-1:0]   dt_q, dt_d;
  logic [OW-1:0]   x_q, x_d;
  logic [DW-1:0]   g_q, g_d;
  logic [HW-1:0]   hi_q, hi_d;
  logic [DW-1:0]   lo_q, lo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   div_q, div_d;
  logic            div_neg_q, div_neg_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [DW-1:0]   res_drive_q, res_drive_d;
  logic            res_rej_q, res_rej_d;
  logic [DW-1:0]   out_drive_q, out_drive_d;
  logic            out_rej_q, out_rej_d;

  // combinational terms
  logic            in_acc;
  logic            out_free;
  logic [DW-1:0]   meas;
  logic [DW-1:0]   dt_in;
  logic [EW-1:0]   err_in;
  logic [FW-1:0]   diff_in;
  logic [FW-1:0]   diff_mag;
  logic            mul_last;
  logic            mul_sub;
  logic [HW:0]     hi_ext;
  logic [HW:0]     x_ext;
  logic [HW:0]     mul_sum;
  logic [PW-1:0]   prod;
  logic [FW-1:0]   trial;
  logic [OW-1:0]   der;
  logic [24:0]     acc_inc;
  logic [AW:0]     acc_sum;
  logic [AW-1:0]   acc_new;
  logic [SW-1:0]   prod_p;
  logic [SW-1:0]   prod_i;
  logic [SW-1:0]   prod_d;
  logic            sum_in_range;
  logic [DW-1:0]   drive_sat;
  logic [DW-1:0]   drive_clamp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_drive_q;
  assign m_axis_tuser  = out_rej_q;

  assign meas     = s_axis_tdata[DW-1:0];
  assign dt_in    = s_axis_tdata[2*DW-1:DW];
  assign err_in   = {target_q[DW-1], target_q} - {meas[DW-1], meas};
  assign diff_in  = {err_in[EW-1], err_in} - {last_err_q[EW-1], last_err_q};
  assign diff_mag = diff_in[FW-1] ? (~diff_in + FW'(1)) : diff_in;

  // shift-and-add step: the sign bit of a signed gain weighs negative
  assign mul_last = (cnt_q == CW'(DW - 1));
  assign mul_sub  = g_q[0] && mul_last && (phase_q != PhDt);
  assign hi_ext   = {hi_q[HW-1], hi_q};
  assign x_ext    = {{2{x_q[OW-1]}}, x_q};
  assign mul_sum  = mul_sub ? (hi_ext - x_ext) : (g_q[0] ? (hi_ext + x_ext) : hi_ext);
  assign prod     = {hi_q, lo_q};

  // restoring divide step on the magnitude of the error difference
  assign trial = {1'b0, rem_q, div_q[QW-1]} - {2'b00, dt_q};
  assign der   = div_neg_q ? (~{1'b0, div_q} + OW'(1)) : {1'b0, div_q};

  // integral update: floor shift of error*dt to Q16.16, then clamp
  assign acc_inc = prod[32:8];
  assign acc_sum = {accum_q[AW-1], accum_q} + {{(AW + 1 - 25){acc_inc[24]}}, acc_inc};
  always_comb begin
    if ($signed(acc_sum) > $signed({accum_hi_q[AW-1], accum_hi_q})) begin
      acc_new = accum_hi_q;
    end else if ($signed(acc_sum) < $signed({accum_lo_q[AW-1], accum_lo_q})) begin
      acc_new = accum_lo_q;
    end else begin
      acc_new = acc_sum[AW-1:0];
    end
  end

  // align each product to Q.24 scale
  assign prod_p = {{(SW - 41){prod[32]}}, prod[32:0], 8'h00};
  assign prod_i = {{(SW - 48){prod[47]}}, prod[47:0]};
  assign prod_d = {{(SW - 58){prod[49]}}, prod[49:0], 8'h00};

  // floor shift by 16, saturate to Q8.8, then clamp to the drive limits
  assign sum_in_range = (&sum_q[SW-1:31]) || !(|sum_q[SW-1:31]);
  assign drive_sat    = sum_in_range ? sum_q[31:16]
                      : (sum_q[SW-1] ? pcu_pkg::DriveMin : pcu_pkg::DriveMax);
  always_comb begin
    if ($signed(drive_sat) > $signed(drive_hi_q)) begin
      drive_clamp = drive_hi_q;
    end else if ($signed(drive_sat) < $signed(drive_lo_q)) begin
      drive_clamp = drive_lo_q;
    end else begin
      drive_clamp = drive_sat;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    gain_p_d    = gain_p_q;
    gain_i_d    = gain_i_q;
    gain_d_d    = gain_d_q;
    target_d    = target_q;
    drive_lo_d  = drive_lo_q;
    drive_hi_d  = drive_hi_q;
    accum_lo_d  = accum_lo_q;
    accum_hi_d  = accum_hi_q;
    accum_d     = accum_q;
    last_err_d  = last_err_q;
    err_d       = err_q;
    dt_d        = dt_q;
    x_d         = x_q;
    g_d         = g_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    div_neg_d   = div_neg_q;
    sum_d       = sum_q;
    res_drive_d = res_drive_q;
    res_rej_d   = res_rej_q;
    out_drive_d = out_drive_q;
    out_rej_d   = out_rej_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcu_pkg::RegGainP:   gain_p_d   = cfg_data_i[DW-1:0];
        pcu_pkg::RegGainI:   gain_i_d   = cfg_data_i[DW-1:0];
        pcu_pkg::RegGainD:   gain_d_d   = cfg_data_i[DW-1:0];
        pcu_pkg::RegTarget:  target_d   = cfg_data_i[DW-1:0];
        pcu_pkg::RegDriveLo: drive_lo_d = cfg_data_i[DW-1:0];
        pcu_pkg::RegDriveHi: drive_hi_d = cfg_data_i[DW-1:0];
        pcu_pkg::RegAccumLo: accum_lo_d = cfg_data_i[AW-1:0];
        pcu_pkg::RegAccumHi: accum_hi_d = cfg_data_i[AW-1:0];
        default: ;
      endcase
    end

    // divider advances on its own once started
    if (div_cnt_q != '0) begin
      div_cnt_d = div_cnt_q - VW'(1);
      if (!trial[FW-1]) begin
        rem_d = trial[DW-1:0];
        div_d = {div_q[QW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DW-2:0], div_q[QW-1]};
        div_d = {div_q[QW-2:0], 1'b0};
      end
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            accum_d    = '0;
            last_err_d = '0;
          end else if (dt_in == '0) begin
            res_drive_d = '0;
            res_rej_d   = 1'b1;
            state_d     = StResult;
          end else begin
            err_d      = err_in;
            dt_d       = dt_in;
            last_err_d = err_in;
            rem_d      = '0;
            div_d      = {diff_mag[EW-1:0], {DW{1'b0}}};
            div_neg_d  = diff_in[FW-1];
            div_cnt_d  = VW'(pcu_pkg::DivSteps);
            x_d        = {{(OW - EW){err_in[EW-1]}}, err_in};
            g_d        = dt_in;
            hi_d       = '0;
            cnt_d      = '0;
            phase_d    = PhDt;
            state_d    = StMul;
          end
        end
      end
      StMul: begin
        hi_d  = mul_sum[HW:1];
        lo_d  = {mul_sum[0], lo_q[DW-1:1]};
        g_d   = {1'b0, g_q[DW-1:1]};
        cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          state_d = StFold;
        end
      end
      StFold: begin
        unique case (phase_q)
          PhDt: begin
            accum_d = acc_new;
            x_d     = {{(OW - EW){err_q[EW-1]}}, err_q};
            g_d     = gain_p_q;
            hi_d    = '0;
            phase_d = PhProp;
            state_d = StMul;
          end
          PhProp: begin
            sum_d   = prod_p;
            x_d     = {{(OW - AW){accum_q[AW-1]}}, accum_q};
            g_d     = gain_i_q;
            hi_d    = '0;
            phase_d = PhInt;
            state_d = StMul;
          end
          PhInt: begin
            // hold until the quotient is complete
            if (div_cnt_q == '0) begin
              sum_d   = sum_q + prod_i;
              x_d     = der;
              g_d     = gain_d_q;
              hi_d    = '0;
              phase_d = PhDer;
              state_d = StMul;
            end
          end
          PhDer: begin
            sum_d   = sum_q + prod_d;
            state_d = StSat;
          end
          default: ;
        endcase
      end
      StSat: begin
        res_drive_d = drive_clamp;
        res_rej_d   = 1'b0;
        state_d     = StResult;
      end
      StResult: begin
        if (out_free) begin
          out_drive_d = res_drive_q;
          out_rej_d   = res_rej_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhDt;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      gain_p_q    <= pcu_pkg::GainPRst;
      gain_i_q    <= pcu_pkg::GainIRst;
      gain_d_q    <= pcu_pkg::GainDRst;
      target_q    <= pcu_pkg::TargetRst;
      drive_lo_q  <= pcu_pkg::DriveLoRst;
      drive_hi_q  <= pcu_pkg::DriveHiRst;
      accum_lo_q  <= pcu_pkg::AccumLoRst;
      accum_hi_q  <= pcu_pkg::AccumHiRst;
      accum_q     <= '0;
      last_err_q  <= '0;
      err_q       <= '0;
      dt_q        <= '0;
      x_q         <= '0;
      g_q         <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      div_neg_q   <= 1'b0;
      sum_q       <= '0;
      res_drive_q <= '0;
      res_rej_q   <= 1'b0;
      out_drive_q <= '0;
      out_rej_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      gain_p_q    <= gain_p_d;
      gain_i_q    <= gain_i_d;
      gain_d_q    <= gain_d_d;
      target_q    <= target_d;
      drive_lo_q  <= drive_lo_d;
      drive_hi_q  <= drive_hi_d;
      accum_lo_q  <= accum_lo_d;
      accum_hi_q  <= accum_hi_d;
      accum_q     <= accum_d;
      last_err_q  <= last_err_d;
      err_q       <= err_d;
      dt_q        <= dt_d;
      x_q         <= x_d;
      g_q         <= g_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      div_neg_q   <= div_neg_d;
      sum_q       <= sum_d;
      res_drive_q <= res_drive_d;
      res_rej_q   <= res_rej_d;
      out_drive_q <= out_drive_d;
      out_rej_q   <= out_rej_d;
    end
  end

endmodule
